@@ hdl/aafe_pkg.sv @@
// ----------------------------------------------------------------------------
// aafe_pkg - shared types and constants of the accelerometer frame encoder
// Transfer structs, ASCII codes, lane stage enables and the decimal digit step.
// ----------------------------------------------------------------------------
package aafe_pkg;

    // Frame geometry
    localparam int FRAME_LEN = 18;
    localparam logic [4:0] LAST_IDX  = 5'(FRAME_LEN - 1);
    localparam logic [4:0] CR_IDX    = 5'(FRAME_LEN - 2);
    localparam logic [4:0] DIG_FIRST = 5'd4;

    // ASCII codes
    localparam logic [7:0] CH_T  = 8'h54;
    localparam logic [7:0] CH_U  = 8'h55;
    localparam logic [7:0] CH_D  = 8'h44;
    localparam logic [7:0] CH_L  = 8'h4C;
    localparam logic [7:0] CH_R  = 8'h52;
    localparam logic [7:0] CH_X  = 8'h58;
    localparam logic [7:0] CH_P  = 8'h50;
    localparam logic [7:0] CH_N  = 8'h4E;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_0  = 8'h30;

    // Action codes
    localparam logic ACT_FRAME = 1'b0;
    localparam logic ACT_TURBO = 1'b1;

    // Orientation codes
    localparam logic [2:0] OR_REC   = 3'd0;
    localparam logic [2:0] OR_LEFT  = 3'd1;
    localparam logic [2:0] OR_RIGHT = 3'd2;
    localparam logic [2:0] OR_UP    = 3'd3;
    localparam logic [2:0] OR_DOWN  = 3'd4;

    typedef struct packed {
        logic              action;
        logic [2:0]        orient_code;
        logic signed [15:0] x_milli_g;
        logic signed [15:0] y_milli_g;
        logic signed [15:0] z_milli_g;
    } t_in_item;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_out_item;

    // Per-stage load enables of the axis lanes
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_lane_en;

    // Four decimal digits, index 3 is the thousands digit
    typedef logic [3:0][3:0] t_digits;

    typedef struct packed {
        logic [3:0]  dig;
        logic [13:0] rem;
    } t_dstep;

    // Split off one decimal digit of value v (v < 10 * unit) by compares
    function automatic t_dstep digit_step(input logic [13:0] v, input logic [13:0] unit);
        t_dstep      res;
        logic [13:0] thr;
        res.dig = 4'd0;
        res.rem = v;
        thr     = 14'd0;
        for (int k = 1; k <= 9; k++) begin
            thr = 14'(thr + unit);
            if (v >= thr) begin
                res.dig = 4'(k);
                res.rem = 14'(v - thr);
            end
        end
        return res;
    endfunction

    // Orientation letter; unused codes map to the recovered letter
    function automatic logic [7:0] orient_letter(input logic [2:0] code);
        logic [7:0] ch;
        case (code)
            OR_REC:   ch = CH_X;
            OR_LEFT:  ch = CH_L;
            OR_RIGHT: ch = CH_R;
            OR_UP:    ch = CH_U;
            OR_DOWN:  ch = CH_D;
            default:  ch = CH_X;
        endcase
        return ch;
    endfunction

endpackage

@@ hdl/aafe_lane.sv @@
// ----------------------------------------------------------------------------
// aafe_lane - one axis lane
// Four-stage pipeline: sign and saturated magnitude modulo 10000, then the
// thousands, hundreds, and tens/units digits, one digit step per stage.
// ----------------------------------------------------------------------------
module aafe_lane (
    input  logic              i_clk,
    input  aafe_pkg::t_lane_en i_en,
    input  logic [15:0]       i_raw,
    output logic              o_pos,
    output aafe_pkg::t_digits o_digits
);
    import aafe_pkg::*;

    logic [15:0] neg;
    logic [14:0] mag;
    logic [13:0] n_m1;
    logic        n_pos1;
    t_dstep      st_th, st_hu, st_te;

    logic        r_pos1, r_pos2, r_pos3, r_pos4;
    logic [13:0] r_m1;
    logic [3:0]  r_th2, r_th3, r_hu3;
    logic [9:0]  r_rem2;
    logic [6:0]  r_rem3;
    t_digits     r_dig4;

    // Sign and magnitude, with the most negative code saturated
    always_comb begin
        neg    = 16'(~i_raw + 16'd1);
        n_pos1 = !i_raw[15] && (i_raw != 16'd0);
        if (!i_raw[15]) begin
            mag = i_raw[14:0];
        end else if (i_raw == 16'h8000) begin
            mag = 15'h7FFF;
        end else begin
            mag = neg[14:0];
        end
        // Keep the low four decimal digits
        if (mag >= 15'd30000) begin
            n_m1 = 14'(mag - 15'd30000);
        end else if (mag >= 15'd20000) begin
            n_m1 = 14'(mag - 15'd20000);
        end else if (mag >= 15'd10000) begin
            n_m1 = 14'(mag - 15'd10000);
        end else begin
            n_m1 = 14'(mag);
        end
    end

    // Digit steps
    always_comb begin
        st_th = digit_step(r_m1, 14'd1000);
        st_hu = digit_step(14'(r_rem2), 14'd100);
        st_te = digit_step(14'(r_rem3), 14'd10);
    end

    // Advance the lane stages
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_pos1 <= n_pos1;
            r_m1   <= n_m1;
        end
        if (i_en.s2) begin
            r_pos2 <= r_pos1;
            r_th2  <= st_th.dig;
            r_rem2 <= st_th.rem[9:0];
        end
        if (i_en.s3) begin
            r_pos3 <= r_pos2;
            r_th3  <= r_th2;
            r_hu3  <= st_hu.dig;
            r_rem3 <= st_hu.rem[6:0];
        end
        if (i_en.s4) begin
            r_pos4    <= r_pos3;
            r_dig4[3] <= r_th3;
            r_dig4[2] <= r_hu3;
            r_dig4[1] <= st_te.dig;
            r_dig4[0] <= st_te.rem[3:0];
        end
    end

    assign o_pos    = r_pos4;
    assign o_digits = r_dig4;

endmodule

@@ hdl/aafe_ser.sv @@
// ----------------------------------------------------------------------------
// aafe_ser - frame merge and byte serializer
// Gathers letter, signs and digits of the three lanes into one frame and
// sends it one byte per transfer through a registered output stage.
// ----------------------------------------------------------------------------
module aafe_ser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_turbo,
    input  logic [7:0]          i_letter,
    input  logic [2:0]          i_pos,
    input  aafe_pkg::t_digits   i_dig_x,
    input  aafe_pkg::t_digits   i_dig_y,
    input  aafe_pkg::t_digits   i_dig_z,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output aafe_pkg::t_out_item o_out_item
);
    import aafe_pkg::*;

    logic        r_busy;
    logic [4:0]  r_idx;
    logic        r_turbo;
    logic [7:0]  r_letter;
    logic [2:0]  r_pos;
    t_digits     r_dig [3];
    logic        r_ov;
    t_out_item   r_item;

    logic        out_ld, emit, at_last, load;
    logic [4:0]  rel;
    logic [1:0]  axis;
    logic [1:0]  slot;
    logic [3:0]  dsel;
    logic [7:0]  cur;

    assign out_ld  = !r_ov || !i_out_stall;
    assign emit    = r_busy && out_ld;
    assign at_last = (r_idx == LAST_IDX);
    assign o_ready = !r_busy || (emit && at_last);
    assign load    = i_valid && o_ready;

    // Select the byte at the current frame position
    always_comb begin
        rel  = 5'(r_idx - DIG_FIRST);
        axis = rel[3:2];
        slot = rel[1:0];
        dsel = r_dig[2'(axis)][2'(2'd3 - slot)];
        if (r_idx == 5'd0) begin
            cur = r_turbo ? CH_T : r_letter;
        end else if (r_idx < DIG_FIRST) begin
            cur = r_turbo ? 8'd0 : (r_pos[2'(r_idx - 5'd1)] ? CH_P : CH_N);
        end else if (r_idx < CR_IDX) begin
            cur = r_turbo ? 8'd0 : 8'(CH_0 + {4'd0, dsel});
        end else if (r_idx == CR_IDX) begin
            cur = CH_CR;
        end else begin
            cur = CH_LF;
        end
    end

    // Hold the frame and step through its bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 5'd0;
            r_ov   <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_idx  <= 5'd0;
            end else if (emit && at_last) begin
                r_busy <= 1'b0;
            end else if (emit) begin
                r_idx <= 5'(r_idx + 5'd1);
            end
            if (out_ld) begin
                r_ov <= emit;
            end
        end
        if (load) begin
            r_turbo  <= i_turbo;
            r_letter <= i_letter;
            r_pos    <= i_pos;
            r_dig[0] <= i_dig_x;
            r_dig[1] <= i_dig_y;
            r_dig[2] <= i_dig_z;
        end
        if (out_ld) begin
            r_item.frame_byte <= cur;
            r_item.last_byte  <= at_last;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_item  = r_item;

endmodule

@@ hdl/accel_ascii_frame_encoder.sv @@
// ----------------------------------------------------------------------------
// accel_ascii_frame_encoder - accelerometer sample to 18-byte ASCII frame
//
// Input channel: i_in_valid / o_in_stall carry one t_in_item per transfer.
// A frame request (action 0) yields 18 output transfers: orientation letter,
// three sign letters, twelve decimal digits, CR, LF (last_byte set on LF).
// A turbo press (action 1) yields nothing; it arms a flag so that the next
// frame request sends 'T', fifteen zero bytes and CR LF instead.
// Output channel: o_out_valid / i_out_stall, one byte per transfer.
// Path: after the request is taken, the first byte passes three more lane
// stages, the serializer load and the output register before it is presented.
// Throughput: one byte per cycle while the receiver does not stall; frames
// follow each other without gaps while up to four more requests sit in the
// lane pipeline. Turbo presses are taken whenever the input is not stalled.
// Reset clears the turbo flag and all pipeline and output valids.
// A stalled receiver holds the current byte; the pipeline backs up and the
// input stalls once all lane stages are occupied.
// ----------------------------------------------------------------------------
module accel_ascii_frame_encoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  aafe_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output aafe_pkg::t_out_item o_out_item
);
    import aafe_pkg::*;

    logic [4:1] rdy;
    logic [4:1] r_v;
    logic [4:1] r_turbo;
    logic [7:0] r_letter [4];
    logic       r_pend;
    logic       n_pend;
    logic       in_acc, frame_go, ser_rdy;
    t_lane_en   en;
    logic [2:0] pos;
    t_digits    dig_x, dig_y, dig_z;

    // Ready chain through the lane stages
    always_comb begin
        rdy[4] = !r_v[4] || ser_rdy;
        for (int k = 3; k >= 1; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign o_in_stall = !rdy[1];
    assign in_acc     = i_in_valid && rdy[1];
    assign frame_go   = in_acc && (i_in_item.action == ACT_FRAME);
    assign n_pend     = in_acc ? (i_in_item.action == ACT_TURBO) : r_pend;

    assign en.s1 = rdy[1];
    assign en.s2 = rdy[2];
    assign en.s3 = rdy[3];
    assign en.s4 = rdy[4];

    // Hold turbo flag and advance the sideband pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_v    <= '0;
        end else begin
            r_pend <= n_pend;
            if (rdy[1]) begin
                r_v[1] <= frame_go;
            end
            for (int k = 2; k <= 4; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
        if (rdy[1]) begin
            r_turbo[1]  <= r_pend;
            r_letter[0] <= orient_letter(i_in_item.orient_code);
        end
        for (int k = 2; k <= 4; k++) begin
            if (rdy[k]) begin
                r_turbo[k]    <= r_turbo[k-1];
                r_letter[k-1] <= r_letter[k-2];
            end
        end
    end

    aafe_lane u_lane_x (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_raw    (i_in_item.x_milli_g),
        .o_pos    (pos[0]),
        .o_digits (dig_x)
    );

    aafe_lane u_lane_y (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_raw    (i_in_item.y_milli_g),
        .o_pos    (pos[1]),
        .o_digits (dig_y)
    );

    aafe_lane u_lane_z (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_raw    (i_in_item.z_milli_g),
        .o_pos    (pos[2]),
        .o_digits (dig_z)
    );

    aafe_ser u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_v[4]),
        .o_ready     (ser_rdy),
        .i_turbo     (r_turbo[4]),
        .i_letter    (r_letter[3]),
        .i_pos       (pos),
        .i_dig_x     (dig_x),
        .i_dig_y     (dig_y),
        .i_dig_z     (dig_z),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
